/* rtl/core/bda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg
// Types and constants shared by the decimal text formatter and its checker.
// ----------------------------------------------------------------------------
package bda_pkg;

	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;

	localparam logic [6:0] CHAR_ZERO  = 7'd48;
	localparam logic [6:0] CHAR_NINE  = 7'd57;
	localparam logic [6:0] CHAR_MINUS = 7'd45;

	localparam logic FUNC_SIGNED   = 1'b0;
	localparam logic FUNC_UNSIGNED = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last;
	} chr_item_t;

endpackage

/* rtl/core/binary_to_decimal_ascii_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Turns a 32-bit word, signed or unsigned, into decimal ASCII characters.
// ----------------------------------------------------------------------------
// A word enters a five-stage pipeline (magnitude, then four stages of eight
// shift-and-add-3 steps each) whose last stage feeds the character
// serialiser. The serialiser sends one character per cycle unless chr_stall
// holds it, most significant digit first, with a leading '-' for a negative
// signed word; a word has 1 to 11 characters, and the next word is taken as
// its last one goes out. Words behind it wait in the pipeline, so up to five
// further words can be taken while a number is being sent.
module binary_to_decimal_ascii_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  bda_pkg::cmd_item_t   cmd,
	output logic                 chr_valid,
	input  logic                 chr_stall,
	output bda_pkg::chr_item_t   chr
);
	import bda_pkg::*;

	function automatic logic [BCD_W-1:0] dabble8(input logic [BCD_W-1:0] bcd_in,
		input logic [7:0] bits);
		logic [BCD_W-1:0] b;
		b = bcd_in;
		for (int s = 7; s >= 0; s--) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (b[d*DIGIT_W +: DIGIT_W] >= 4'd5)
					b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + 4'd3;
			end
			b = {b[BCD_W-2:0], bits[s]};
		end
		return b;
	endfunction

	// pipeline registers
	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic              neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [31:0]       mag_s1;
	logic [23:0]       rest_s2;
	logic [15:0]       rest_s3;
	logic [7:0]        rest_s4;
	logic [BCD_W-1:0]  bcd_s2, bcd_s3, bcd_s4, bcd_s5;
	logic              ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;

	// serialiser
	logic              busy_q;
	logic              neg_pend_q;
	logic [3:0]        idx_q;
	logic [DIGIT_W-1:0] dig_q [NUM_DIGITS];
	logic              slot_free;
	logic              ser_ready;
	logic              neg_in;
	logic [3:0]        lead;

	assign slot_free = !chr_valid || !chr_stall;
	assign ser_ready = !busy_q || (slot_free && !neg_pend_q && idx_q == 4'd0);

	assign ready_s5 = !valid_s5 || ser_ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign cmd_stall = !ready_s1;

	assign neg_in = (cmd.func == FUNC_SIGNED) && cmd.value[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= cmd_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			neg_s1 <= neg_in;
			mag_s1 <= neg_in ? (~cmd.value + 32'd1) : cmd.value;
		end
		if (ready_s2) begin
			neg_s2  <= neg_s1;
			bcd_s2  <= dabble8('0, mag_s1[31:24]);
			rest_s2 <= mag_s1[23:0];
		end
		if (ready_s3) begin
			neg_s3  <= neg_s2;
			bcd_s3  <= dabble8(bcd_s2, rest_s2[23:16]);
			rest_s3 <= rest_s2[15:0];
		end
		if (ready_s4) begin
			neg_s4  <= neg_s3;
			bcd_s4  <= dabble8(bcd_s3, rest_s3[15:8]);
			rest_s4 <= rest_s3[7:0];
		end
		if (ready_s5) begin
			neg_s5 <= neg_s4;
			bcd_s5 <= dabble8(bcd_s4, rest_s4);
		end
	end

	// highest non-zero digit, or the units digit for zero
	always_comb begin
		lead = 4'd0;
		for (int d = 1; d < NUM_DIGITS; d++) begin
			if (bcd_s5[d*DIGIT_W +: DIGIT_W] != 4'd0)
				lead = 4'(d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			neg_pend_q <= 1'b0;
			idx_q      <= 4'd0;
			chr_valid  <= 1'b0;
		end else begin
			if (slot_free)
				chr_valid <= busy_q;
			// a new word is taken when the serialiser is idle or as its last character goes out
			if (valid_s5 && ser_ready) begin
				busy_q     <= 1'b1;
				neg_pend_q <= neg_s5;
				idx_q      <= lead;
			end else if (busy_q && slot_free) begin
				if (neg_pend_q) begin
					neg_pend_q <= 1'b0;
				end else begin
					if (idx_q == 4'd0)
						busy_q <= 1'b0;
					else
						idx_q <= idx_q - 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s5 && ser_ready) begin
			for (int d = 0; d < NUM_DIGITS; d++)
				dig_q[d] <= bcd_s5[d*DIGIT_W +: DIGIT_W];
		end
		if (busy_q && slot_free) begin
			if (neg_pend_q) begin
				chr.char_code <= CHAR_MINUS;
				chr.last      <= 1'b0;
			end else begin
				chr.char_code <= CHAR_ZERO + {3'b000, dig_q[idx_q]};
				chr.last      <= (idx_q == 4'd0);
			end
		end
	end

endmodule

/* rtl/core/bda_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_checker
// Port-level checks on the character stream of the decimal text formatter.
// ----------------------------------------------------------------------------
module bda_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input bda_pkg::cmd_item_t  cmd,
	input logic                chr_valid,
	input logic                chr_stall,
	input bda_pkg::chr_item_t  chr
);
	import bda_pkg::*;

	// a stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && chr_stall |=> chr_valid && $stable(chr))
		else $error("stalled character changed");

	a_legal: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid |-> chr.char_code == CHAR_MINUS ||
			(chr.char_code >= CHAR_ZERO && chr.char_code <= CHAR_NINE))
		else $error("character out of range");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && chr.char_code == CHAR_MINUS |-> !chr.last)
		else $error("sign sent as last character");

	// the sign is followed at once by a non-zero leading digit
	a_after_minus: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && !chr_stall && chr.char_code == CHAR_MINUS |=>
			chr_valid && chr.char_code != CHAR_MINUS && chr.char_code != CHAR_ZERO)
		else $error("bad character after sign");

endmodule

bind binary_to_decimal_ascii_top bda_checker u_bda_checker (.*);
